>>> hw/rtl/image_upload_rect_walker_defines.svh
// Assertion macros shared by the image upload rectangle walker.
`ifndef IMAGE_UPLOAD_RECT_WALKER_DEFINES_SVH
`define IMAGE_UPLOAD_RECT_WALKER_DEFINES_SVH

`ifndef SYNTH
`define IURW_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("image_upload_rect_walker: same-cycle check failed");
`define IURW_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("image_upload_rect_walker: next-cycle check failed");
`else
`define IURW_ASSERT_IMPL(label, clk, rst, ante, cons)
`define IURW_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

>>> hw/rtl/iurw_pkg.sv
`default_nettype none

package iurw_pkg;

  localparam logic [2:0] FMT_CT32 = 3'd0;
  localparam logic [2:0] FMT_CT24 = 3'd1;
  localparam logic [2:0] FMT_CT16 = 3'd2;
  localparam logic [2:0] FMT_T8   = 3'd3;
  localparam logic [2:0] FMT_T4   = 3'd4;
  localparam logic [2:0] FMT_T8H  = 3'd5;
  localparam logic [2:0] FMT_T4HL = 3'd6;
  localparam logic [2:0] FMT_T4HH = 3'd7;

  localparam logic [1:0] STAT_WRITTEN = 2'd0;
  localparam logic [1:0] STAT_STARTED = 2'd1;
  localparam logic [1:0] STAT_NO_XFER = 2'd2;
  localparam logic [1:0] STAT_OVERRUN = 2'd3;

  localparam logic [2:0] REG_PIXEL_FORMAT  = 3'd0;
  localparam logic [2:0] REG_DEST_X_ORIGIN = 3'd1;
  localparam logic [2:0] REG_DEST_Y_ORIGIN = 3'd2;
  localparam logic [2:0] REG_RECT_WIDTH    = 3'd3;
  localparam logic [2:0] REG_RECT_HEIGHT   = 3'd4;

  localparam int CFG_DATA_W = 12;
  localparam int CFG_INDEX_W = 3;
  localparam int COORD_W = 11;
  localparam int CNT_W = 12;
  localparam int BUDGET_W = 25;

  localparam logic [BUDGET_W-1:0] BUDGET_MAX = {BUDGET_W{1'b1}};

  localparam logic [31:0] MASK_CT32 = 32'hFFFF_FFFF;
  localparam logic [31:0] MASK_CT24 = 32'h00FF_FFFF;
  localparam logic [31:0] MASK_CT16 = 32'h0000_FFFF;
  localparam logic [31:0] MASK_BYTE = 32'h0000_00FF;
  localparam logic [31:0] MASK_T8H  = 32'hFF00_0000;
  localparam logic [31:0] MASK_T4HL = 32'h0F00_0000;
  localparam logic [31:0] MASK_T4HH = 32'hF000_0000;

  typedef struct packed {
    logic [CNT_W-1:0] col;
    logic [CNT_W-1:0] row;
  } pos_t;

  typedef struct packed {
    logic               write_valid;
    logic [COORD_W-1:0] pixel_x;
    logic [COORD_W-1:0] pixel_y;
    logic [31:0]        write_value;
    logic [31:0]        write_mask;
    logic [1:0]         status;
    logic               transfer_done;
    logic               last;
  } res_t;

endpackage

`default_nettype wire

>>> hw/rtl/image_upload_rect_walker.sv
// Image upload rectangle walker. A start transaction (kind 0) loads the byte budget from
// width, height and pixel format and clears the column and row counters; each data
// transaction (kind 1) becomes one pixel write, or two for the t4hl and t4hh nibble
// formats, at the current column and row offset by the destination origin and wrapped
// at COORD_WRAP. Data with no transfer open or beyond the budget yields a single status
// result. The input is taken straight into the walker logic and results land in a
// two-entry output queue; a result reaches the output the cycle after acceptance if the
// queue is otherwise empty. A new transaction can be taken every cycle while the output
// takes results, even with one waiting; nibble formats take one only once the single
// output port drains both results of the last one. Configuration is written through
// the plain write port and must only change while no results are outstanding.
`default_nettype none

`include "image_upload_rect_walker_defines.svh"

module image_upload_rect_walker
  import iurw_pkg::*;
#(
  parameter int COORD_WRAP = 2048
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_write_en,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                   in_valid,
  output      logic                   in_ready,
  input  wire logic                   kind,
  input  wire logic [31:0]            data_unit,
  output      logic                   out_valid,
  input  wire logic                   out_ready,
  output      logic                   write_valid,
  output      logic [COORD_W-1:0]     pixel_x,
  output      logic [COORD_W-1:0]     pixel_y,
  output      logic [31:0]            write_value,
  output      logic [31:0]            write_mask,
  output      logic [1:0]             status,
  output      logic                   transfer_done,
  output      logic                   last
);

  localparam int SUM_W = CNT_W + 1;
  localparam int SUM_MAX = (1 << CNT_W) - 1 + (1 << COORD_W) - 1;
  localparam int QMAX = SUM_MAX / COORD_WRAP;

  logic [2:0]          pixel_format;
  logic [COORD_W-1:0]  dest_x_origin;
  logic [COORD_W-1:0]  dest_y_origin;
  logic [CNT_W-1:0]    rect_width;
  logic [CNT_W-1:0]    rect_height;

  logic [BUDGET_W-1:0] bytes_remaining;
  logic [BUDGET_W-1:0] bytes_remaining_next;
  pos_t                pos;
  pos_t                pos_next;

  res_t                q [2];
  res_t                q_next [2];
  logic [1:0]          cnt;
  logic [1:0]          cnt_next;

  logic                pop;
  logic [1:0]          cnt_pop;
  logic                nibble_fmt;
  logic                accept;
  logic                two;
  logic [CNT_W-1:0]    limit;
  pos_t                pos1;
  pos_t                pos2;
  logic [BUDGET_W-1:0] need;
  logic [2*CNT_W-1:0]  area;
  logic [2*CNT_W+2:0]  scaled;
  logic [BUDGET_W-1:0] budget;
  logic [BUDGET_W-1:0] remain;
  logic [31:0]         mask0;
  logic [31:0]         value0;
  logic [31:0]         value1;
  res_t                r0;
  res_t                r1;

  function automatic logic [COORD_W-1:0] wrap_coord(input logic [CNT_W-1:0] cnt_val,
                                                    input logic [COORD_W-1:0] origin);
    logic [SUM_W-1:0] s;
    logic [SUM_W-1:0] r;
    s = {1'b0, cnt_val} + {{(SUM_W-COORD_W){1'b0}}, origin};
    r = s;
    for (int k = 1; k <= QMAX; k++) begin
      if (s >= SUM_W'(k * COORD_WRAP)) begin
        r = s - SUM_W'(k * COORD_WRAP);
      end
    end
    return r[COORD_W-1:0];
  endfunction

  function automatic pos_t advance(input pos_t p, input logic [CNT_W-1:0] lim);
    pos_t n;
    n.col = p.col + 1'b1;
    n.row = p.row;
    if (n.col == lim) begin
      n.col = '0;
      n.row = p.row + 1'b1;
    end
    return n;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_format <= FMT_CT32;
      dest_x_origin <= '0;
      dest_y_origin <= '0;
      rect_width <= '0;
      rect_height <= '0;
    end else if (cfg_write_en) begin
      case (cfg_index)
        REG_PIXEL_FORMAT:  pixel_format <= cfg_data[2:0];
        REG_DEST_X_ORIGIN: dest_x_origin <= cfg_data[COORD_W-1:0];
        REG_DEST_Y_ORIGIN: dest_y_origin <= cfg_data[COORD_W-1:0];
        REG_RECT_WIDTH:    rect_width <= cfg_data[CNT_W-1:0];
        REG_RECT_HEIGHT:   rect_height <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    pop = (cnt != 2'd0) && out_ready;
    cnt_pop = cnt - {1'b0, pop};
    nibble_fmt = (pixel_format == FMT_T4HL) || (pixel_format == FMT_T4HH);
    in_ready = ({1'b0, cnt_pop} + (nibble_fmt ? 3'd2 : 3'd1)) <= 3'd2;
    accept = in_valid && in_ready;

    limit = (pixel_format == FMT_T4) ? {1'b0, rect_width[CNT_W-1:1]} : rect_width;
    pos1 = advance(pos, limit);
    pos2 = advance(pos1, limit);

    case (pixel_format)
      FMT_CT32: need = BUDGET_W'(4);
      FMT_CT24: need = BUDGET_W'(3);
      FMT_CT16: need = BUDGET_W'(2);
      default:  need = BUDGET_W'(1);
    endcase

    area = rect_width * rect_height;
    case (pixel_format)
      FMT_CT32: scaled = {1'b0, area, 2'b00};
      FMT_CT24: scaled = {2'b00, area, 1'b0} + {3'b000, area};
      FMT_CT16: scaled = {2'b00, area, 1'b0};
      FMT_T4, FMT_T4HL, FMT_T4HH: scaled = {4'b0000, area[2*CNT_W-1:1]};
      default:  scaled = {3'b000, area};
    endcase
    budget = (scaled > {2'b00, BUDGET_MAX}) ? BUDGET_MAX : scaled[BUDGET_W-1:0];
    remain = bytes_remaining - need;

    case (pixel_format)
      FMT_CT32: mask0 = MASK_CT32;
      FMT_CT24: mask0 = MASK_CT24;
      FMT_CT16: mask0 = MASK_CT16;
      FMT_T8H:  mask0 = MASK_T8H;
      FMT_T4HL: mask0 = MASK_T4HL;
      FMT_T4HH: mask0 = MASK_T4HH;
      default:  mask0 = MASK_BYTE;
    endcase
    case (pixel_format)
      FMT_T8H: begin
        value0 = {data_unit[7:0], 24'h0};
        value1 = '0;
      end
      FMT_T4HL: begin
        value0 = {4'h0, data_unit[3:0], 24'h0};
        value1 = {4'h0, data_unit[7:4], 24'h0};
      end
      FMT_T4HH: begin
        value0 = {data_unit[3:0], 28'h0};
        value1 = {data_unit[7:4], 28'h0};
      end
      default: begin
        value0 = data_unit & mask0;
        value1 = '0;
      end
    endcase

    r0 = '0;
    r0.last = 1'b1;
    r1 = '0;
    two = 1'b0;
    bytes_remaining_next = bytes_remaining;
    pos_next = pos;

    if (!kind) begin
      r0.status = STAT_STARTED;
      bytes_remaining_next = budget;
      pos_next = '0;
    end else if (bytes_remaining == '0) begin
      r0.status = STAT_NO_XFER;
    end else if (bytes_remaining < need) begin
      r0.status = STAT_OVERRUN;
    end else begin
      bytes_remaining_next = remain;
      r0.write_valid = 1'b1;
      r0.status = STAT_WRITTEN;
      r0.pixel_x = wrap_coord(pos.col, dest_x_origin);
      r0.pixel_y = wrap_coord(pos.row, dest_y_origin);
      r0.write_value = value0;
      r0.write_mask = mask0;
      if (nibble_fmt) begin
        two = 1'b1;
        r0.last = 1'b0;
        r1.write_valid = 1'b1;
        r1.status = STAT_WRITTEN;
        r1.pixel_x = wrap_coord(pos1.col, dest_x_origin);
        r1.pixel_y = wrap_coord(pos1.row, dest_y_origin);
        r1.write_value = value1;
        r1.write_mask = mask0;
        r1.transfer_done = (remain == '0);
        r1.last = 1'b1;
        pos_next = pos2;
      end else begin
        r0.transfer_done = (remain == '0);
        pos_next = pos1;
      end
    end

    q_next[0] = q[0];
    q_next[1] = q[1];
    cnt_next = cnt_pop;
    if (pop) begin
      q_next[0] = q[1];
    end
    if (accept) begin
      q_next[cnt_pop[0]] = r0;
      if (two) begin
        q_next[1] = r1;
      end
      cnt_next = cnt_pop + (two ? 2'd2 : 2'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      bytes_remaining <= '0;
      pos <= '0;
    end else begin
      cnt <= cnt_next;
      if (accept) begin
        bytes_remaining <= bytes_remaining_next;
        pos <= pos_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    q[0] <= q_next[0];
    q[1] <= q_next[1];
  end

  assign out_valid = (cnt != 2'd0);
  assign write_valid = q[0].write_valid;
  assign pixel_x = q[0].pixel_x;
  assign pixel_y = q[0].pixel_y;
  assign write_value = q[0].write_value;
  assign write_mask = q[0].write_mask;
  assign status = q[0].status;
  assign transfer_done = q[0].transfer_done;
  assign last = q[0].last;

  `IURW_ASSERT_IMPL(a_nonwrite_clean, clk, rst, out_valid && !write_valid,
                    (write_mask == '0) && (pixel_x == '0) && !transfer_done && last)
  `IURW_ASSERT_IMPL(a_first_half_paired, clk, rst, out_valid && !last,
                    write_valid && (cnt == 2'd2) && q[1].write_valid && q[1].last)
  `IURW_ASSERT_NEXT(a_budget_no_growth, clk, rst, accept && kind,
                    bytes_remaining <= $past(bytes_remaining))

endmodule

`default_nettype wire
